>>> sv/msacs_pkg.sv
// Shared types and constants for the alignment column scorer.
// No dependencies; imported by every module of the block.
package msacs_pkg;

    // Default configuration of the block.
    localparam int DEF_MAX_SEQUENCES = 1024;
    localparam int DEF_MAX_COLUMNS   = 65536;
    localparam int DEF_ALPHABET_SIZE = 255;

    // Fixed field widths of the result request.
    localparam int SYM_W      = 8;
    localparam int DIST_W     = 11;
    localparam int PAIR_W     = 19;
    localparam int TOT_DIST_W = 27;
    localparam int TOT_PAIR_W = 35;

    // Reset value of the gap register (ASCII dash).
    localparam logic [SYM_W-1:0] GAP_RESET = 8'd45;

    // Saturation limits of the column fields and of the running totals.
    localparam logic [DIST_W-1:0]     DIST_FIELD_MAX = 11'd2047;
    localparam logic [PAIR_W-1:0]     PAIR_FIELD_MAX = 19'd524287;
    localparam logic [TOT_DIST_W:0]   TOT_DIST_MAX   = 28'd67108864;
    localparam logic [TOT_PAIR_W+1:0] TOT_PAIR_MAX   = 37'd34326183936;

    // Classification of one symbol, passed from front to back.
    typedef struct packed {
        logic in_alpha;   // symbol lies inside the alphabet
        logic drop;       // column already full, symbol is discarded
        logic col_end;    // last symbol of the column
        logic aln_end;    // last symbol of the alignment
        logic ovf;        // some symbol of this column was dropped
    } t_item_flags;

    localparam int FLAGS_W = $bits(t_item_flags);

endpackage

>>> sv/msa_column_scorer.sv
// Top level of the alignment column scorer: gap register, front end,
// queue and back end. Depends on msacs_pkg, msacs_front, msacs_fifo, msacs_back.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall   | symbol, column and alignment marks
//  out     | output    | o_out_valid / i_out_stall | one column summary per column end
//  cfg     | input     | i_cfg_valid / o_cfg_ready | gap symbol
//
// One symbol is taken per cycle while o_in_stall is low; a column result passes from
// the queue (histogram read on leaving it) through the update stage and the summary
// register into the output register. The histogram is a single-port-write memory
// read as a symbol enters the update stage, with forwarding of the previous write.
// Reset is synchronous and clears all control state; histogram bins need no
// clearing since per-bin valid bits drop at each column end.
// An output stall freezes the back end; the four-entry queue then fills and
// raises o_in_stall.
module msa_column_scorer import msacs_pkg::*; #(
    parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SYM_W-1:0]      i_symbol,
    input  logic                  i_last_in_column,
    input  logic                  i_last_in_alignment,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SYM_W-1:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SYM_W-1:0]      o_consensus_symbol,
    output logic                  o_all_gap_column,
    output logic [DIST_W-1:0]     o_column_distance,
    output logic [PAIR_W-1:0]     o_column_pair_mismatches,
    output logic [TOT_DIST_W-1:0] o_total_distance,
    output logic [TOT_PAIR_W-1:0] o_total_pair_mismatches,
    output logic                  o_shape_error,
    output logic                  o_overflow,
    output logic                  o_end_of_alignment
);

    localparam int SW = $clog2(MAX_SEQUENCES + 1);
    localparam int QW = SYM_W + 2 * SW + FLAGS_W;

    // Gap register.
    logic [SYM_W-1:0] r_gap;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_valid) begin
            r_gap <= i_cfg_data;
        end
    end

    logic             w_push;
    logic [SYM_W-1:0] w_f_sym;
    logic [SW-1:0]    w_f_pos;
    logic [SW-1:0]    w_f_n;
    t_item_flags      w_f_flags;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    logic [QW-1:0]    w_head;
    logic [SYM_W-1:0] w_h_sym;
    logic [SW-1:0]    w_h_pos;
    logic [SW-1:0]    w_h_n;
    t_item_flags      w_h_flags;

    assign o_in_stall = w_full;

    // Front end: classification and position tracking.
    msacs_front #(
        .MAX_SEQUENCES (MAX_SEQUENCES),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .SW            (SW)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_in_valid),
        .i_symbol            (i_symbol),
        .i_last_in_column    (i_last_in_column),
        .i_last_in_alignment (i_last_in_alignment),
        .i_full              (w_full),
        .o_push              (w_push),
        .o_sym               (w_f_sym),
        .o_pos               (w_f_pos),
        .o_n                 (w_f_n),
        .o_flags             (w_f_flags)
    );

    // Queue between the two halves.
    msacs_fifo #(
        .W     (QW),
        .DEPTH (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_sym, w_f_pos, w_f_n, w_f_flags}),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    assign {w_h_sym, w_h_pos, w_h_n, w_h_flags} = w_head;

    // Back end: histogram, consensus and totals.
    msacs_back #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .SW            (SW)
    ) u_back (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_gap                    (r_gap),
        .i_empty                  (w_empty),
        .i_sym                    (w_h_sym),
        .i_pos                    (w_h_pos),
        .i_n                      (w_h_n),
        .i_flags                  (w_h_flags),
        .o_pop                    (w_pop),
        .i_out_stall              (i_out_stall),
        .o_out_valid              (o_out_valid),
        .o_consensus_symbol       (o_consensus_symbol),
        .o_all_gap_column         (o_all_gap_column),
        .o_column_distance        (o_column_distance),
        .o_column_pair_mismatches (o_column_pair_mismatches),
        .o_total_distance         (o_total_distance),
        .o_total_pair_mismatches  (o_total_pair_mismatches),
        .o_shape_error            (o_shape_error),
        .o_overflow               (o_overflow),
        .o_end_of_alignment       (o_end_of_alignment)
    );

endmodule

>>> sv/msacs_front.sv
// Front end of the column scorer: accepts symbols and classifies them.
// Tracks the position in the column. Depends on msacs_pkg.
module msacs_front import msacs_pkg::*; #(
    parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int SW            = $clog2(MAX_SEQUENCES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_last_in_column,
    input  logic              i_last_in_alignment,
    input  logic              i_full,
    output logic              o_push,
    output logic [SYM_W-1:0]  o_sym,
    output logic [SW-1:0]     o_pos,
    output logic [SW-1:0]     o_n,
    output t_item_flags       o_flags
);

    logic [SW-1:0] r_pos;
    logic [SW-1:0] n_pos;
    logic          r_drop_seen;
    logic          n_drop_seen;
    logic          w_drop;

    // A request is taken whenever the queue has room.
    assign o_push = i_valid & ~i_full;
    assign w_drop = (r_pos >= SW'(MAX_SEQUENCES));

    // Classify the symbol and compute the column length after it.
    always_comb begin
        o_sym            = i_symbol;
        o_pos            = r_pos;
        o_n              = w_drop ? r_pos : r_pos + SW'(1);
        o_flags.in_alpha = (i_symbol < SYM_W'(ALPHABET_SIZE));
        o_flags.drop     = w_drop;
        o_flags.col_end  = i_last_in_column;
        o_flags.aln_end  = i_last_in_column & i_last_in_alignment;
        o_flags.ovf      = r_drop_seen | w_drop;
    end

    // Position and drop tracking restart at each column end.
    always_comb begin
        n_pos       = r_pos;
        n_drop_seen = r_drop_seen;
        if (o_push) begin
            if (i_last_in_column) begin
                n_pos       = '0;
                n_drop_seen = 1'b0;
            end else begin
                n_pos       = o_n;
                n_drop_seen = r_drop_seen | w_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_drop_seen <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_drop_seen <= n_drop_seen;
        end
    end

endmodule

>>> sv/msacs_fifo.sv
// Short queue between front and back of the column scorer.
// Generic data width; depends on msacs_pkg only for the default width FLAGS_W.
module msacs_fifo import msacs_pkg::*; #(
    parameter int W     = FLAGS_W,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_data  = r_mem[r_rd];

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

>>> sv/msacs_back.sv
// Back end of the column scorer: histogram update, consensus tracking,
// column summary and running totals. Depends on msacs_pkg.
module msacs_back import msacs_pkg::*; #(
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int SW            = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SYM_W-1:0]       i_gap,
    input  logic                   i_empty,
    input  logic [SYM_W-1:0]       i_sym,
    input  logic [SW-1:0]          i_pos,
    input  logic [SW-1:0]          i_n,
    input  t_item_flags            i_flags,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [SYM_W-1:0]       o_consensus_symbol,
    output logic                   o_all_gap_column,
    output logic [DIST_W-1:0]      o_column_distance,
    output logic [PAIR_W-1:0]      o_column_pair_mismatches,
    output logic [TOT_DIST_W-1:0]  o_total_distance,
    output logic [TOT_PAIR_W-1:0]  o_total_pair_mismatches,
    output logic                   o_shape_error,
    output logic                   o_overflow,
    output logic                   o_end_of_alignment
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int PW = 2 * SW;
    localparam int CW = $clog2(MAX_COLUMNS + 1);

    // Whole back pipeline moves when the output register can take a request.
    logic w_adv;
    assign w_adv = ~o_out_valid | ~i_out_stall;
    assign o_pop = w_adv & ~i_empty;

    // Histogram memory, valid bit per bin for the current column.
    logic [SW-1:0]      r_hist [ALPHABET_SIZE];
    logic [SW-1:0]      r_rd;
    logic               r_hvld [ALPHABET_SIZE];

    // Update stage registers.
    logic               r_b_valid;
    logic [SYM_W-1:0]   r_b_sym;
    logic [SW-1:0]      r_b_pos;
    logic [SW-1:0]      r_b_n;
    t_item_flags        r_b_flags;
    logic               r_fwd;
    logic [SW-1:0]      r_last_now;

    // Running per-column state.
    logic [SW-1:0]      r_best_cnt;
    logic [SYM_W-1:0]   r_best_sym;
    logic [PW-1:0]      r_acc;

    logic               w_wr;
    logic               w_head_wr;
    logic [AW-1:0]      w_addr;
    logic [AW-1:0]      w_head_addr;
    logic [SW-1:0]      w_prior;
    logic [SW-1:0]      w_now;
    logic [SW-1:0]      w_add;
    logic               w_better;
    logic [SW-1:0]      w_best_cnt;
    logic [SYM_W-1:0]   w_best_sym;
    logic [PW-1:0]      w_acc;

    assign w_wr        = r_b_valid & r_b_flags.in_alpha & ~r_b_flags.drop;
    assign w_head_wr   = i_flags.in_alpha & ~i_flags.drop;
    assign w_addr      = r_b_sym[AW-1:0];
    assign w_head_addr = i_sym[AW-1:0];

    // Count lookup with forwarding of the previous write to the same bin.
    always_comb begin
        if (r_fwd) begin
            w_prior = r_last_now;
        end else if (r_hvld[w_addr]) begin
            w_prior = r_rd;
        end else begin
            w_prior = '0;
        end
        w_now = w_prior + SW'(1);
        if (r_b_flags.drop) begin
            w_add = '0;
        end else if (r_b_flags.in_alpha) begin
            w_add = r_b_pos - w_prior;
        end else begin
            w_add = r_b_pos;
        end
        w_better = w_wr && (r_b_sym != i_gap) &&
                   ((w_now > r_best_cnt) ||
                    ((w_now == r_best_cnt) && (r_b_sym < r_best_sym)));
        w_best_cnt = w_better ? w_now : r_best_cnt;
        w_best_sym = w_better ? r_b_sym : r_best_sym;
        w_acc      = r_acc + PW'(w_add);
    end

    // Histogram write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_adv && w_wr) begin
            r_hist[w_addr] <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd <= r_hist[w_head_addr];
        end
    end

    // Bin valid bits, all cleared at the column end.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (!i_rst_n) begin
                r_hvld[i] <= 1'b0;
            end else if (w_adv && r_b_valid) begin
                if (r_b_flags.col_end) begin
                    r_hvld[i] <= 1'b0;
                end else if (w_wr && (w_addr == AW'(i))) begin
                    r_hvld[i] <= 1'b1;
                end
            end
        end
    end

    // Update stage load and forwarding flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= ~i_empty;
            r_fwd     <= w_wr && w_head_wr && ~r_b_flags.col_end && (r_b_sym == i_sym);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_sym    <= i_sym;
            r_b_pos    <= i_pos;
            r_b_n      <= i_n;
            r_b_flags  <= i_flags;
            r_last_now <= w_now;
        end
    end

    // Consensus and pair tracking within the column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_cnt <= '0;
            r_best_sym <= GAP_RESET;
            r_acc      <= '0;
        end else if (w_adv && r_b_valid) begin
            if (r_b_flags.col_end) begin
                r_best_cnt <= '0;
                r_best_sym <= i_gap;
                r_acc      <= '0;
            end else begin
                r_best_cnt <= w_best_cnt;
                r_best_sym <= w_best_sym;
                r_acc      <= w_acc;
            end
        end
    end

    // Column summary register.
    logic               r_c_valid;
    logic [SW-1:0]      r_c_n;
    logic [SW-1:0]      r_c_best;
    logic [SYM_W-1:0]   r_c_sym;
    logic [PW-1:0]      r_c_pairs;
    logic               r_c_ovf;
    logic               r_c_aln;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid & r_b_flags.col_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_n     <= r_b_n;
            r_c_best  <= w_best_cnt;
            r_c_sym   <= w_best_sym;
            r_c_pairs <= w_acc;
            r_c_ovf   <= r_b_flags.ovf;
            r_c_aln   <= r_b_flags.aln_end;
        end
    end

    // Alignment-wide state: totals, sticky flags, column count.
    logic [TOT_DIST_W-1:0] r_tot_d;
    logic [TOT_PAIR_W-1:0] r_tot_p;
    logic                  r_err_shape;
    logic                  r_err_ovf;
    logic [CW-1:0]         r_cidx;
    logic [SW-1:0]         r_first;

    logic [SW-1:0]         w_dist;
    logic [TOT_DIST_W:0]   w_sum_d;
    logic [TOT_PAIR_W+1:0] w_sum_p;
    logic                  w_cidx_full;
    logic                  w_shape;
    logic                  w_ovf;
    logic [TOT_DIST_W-1:0] w_tot_d;
    logic [TOT_PAIR_W-1:0] w_tot_p;
    logic                  w_fin;

    assign w_fin = w_adv & r_c_valid;

    always_comb begin
        w_dist      = r_c_n - r_c_best;
        w_sum_d     = (TOT_DIST_W+1)'(r_tot_d) + (TOT_DIST_W+1)'(w_dist);
        w_sum_p     = (TOT_PAIR_W+2)'(r_tot_p) + (TOT_PAIR_W+2)'(r_c_pairs);
        w_tot_d     = (w_sum_d > TOT_DIST_MAX) ? TOT_DIST_W'(TOT_DIST_MAX)
                                               : TOT_DIST_W'(w_sum_d);
        w_tot_p     = (w_sum_p > TOT_PAIR_MAX) ? TOT_PAIR_W'(TOT_PAIR_MAX)
                                               : TOT_PAIR_W'(w_sum_p);
        w_cidx_full = (r_cidx >= CW'(MAX_COLUMNS));
        w_shape     = r_err_shape || (r_c_n < SW'(2)) ||
                      ((r_cidx != '0) && (r_c_n != r_first));
        w_ovf       = r_err_ovf | r_c_ovf | w_cidx_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_d     <= '0;
            r_tot_p     <= '0;
            r_err_shape <= 1'b0;
            r_err_ovf   <= 1'b0;
            r_cidx      <= '0;
            r_first     <= '0;
        end else if (w_fin) begin
            if (r_c_aln) begin
                r_tot_d     <= '0;
                r_tot_p     <= '0;
                r_err_shape <= 1'b0;
                r_err_ovf   <= 1'b0;
                r_cidx      <= '0;
                r_first     <= '0;
            end else begin
                r_tot_d     <= w_tot_d;
                r_tot_p     <= w_tot_p;
                r_err_shape <= w_shape;
                r_err_ovf   <= w_ovf;
                if (!w_cidx_full) begin
                    r_cidx <= r_cidx + CW'(1);
                end
                if (r_cidx == '0) begin
                    r_first <= r_c_n;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            o_all_gap_column         <= (r_c_best == '0);
            o_consensus_symbol       <= (r_c_best == '0) ? i_gap : r_c_sym;
            o_column_distance        <= (32'(w_dist) > 32'(DIST_FIELD_MAX)) ?
                                        DIST_FIELD_MAX : DIST_W'(w_dist);
            o_column_pair_mismatches <= (64'(r_c_pairs) > 64'(PAIR_FIELD_MAX)) ?
                                        PAIR_FIELD_MAX : PAIR_W'(r_c_pairs);
            o_total_distance         <= w_tot_d;
            o_total_pair_mismatches  <= w_tot_p;
            o_shape_error            <= w_shape;
            o_overflow               <= w_ovf;
            o_end_of_alignment       <= r_c_aln;
        end
    end

endmodule

>>> sv/msacs_checker.sv
// Port-level checks for the alignment column scorer, bound to the top level.
// Depends on msacs_pkg and msa_column_scorer.
module msacs_checker import msacs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_cfg_ready,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DIST_W-1:0]     o_column_distance,
    input logic [PAIR_W-1:0]     o_column_pair_mismatches,
    input logic [TOT_DIST_W-1:0] o_total_distance,
    input logic [TOT_PAIR_W-1:0] o_total_pair_mismatches
);

    // A stalled result request keeps its total pair mismatch count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_total_pair_mismatches))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A running total never falls below the column it includes.
    a_tot_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 38'(o_total_distance) >= 38'(o_column_distance))
        else $error("total distance below column distance");

    a_tot_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 38'(o_total_pair_mismatches) >= 38'(o_column_pair_mismatches))
        else $error("total pair mismatches below column value");

    // The gap register takes a write in any cycle.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind msa_column_scorer msacs_checker u_checker (
    .i_clk                    (i_clk),
    .i_rst_n                  (i_rst_n),
    .o_cfg_ready              (o_cfg_ready),
    .o_out_valid              (o_out_valid),
    .i_out_stall              (i_out_stall),
    .o_column_distance        (o_column_distance),
    .o_column_pair_mismatches (o_column_pair_mismatches),
    .o_total_distance         (o_total_distance),
    .o_total_pair_mismatches  (o_total_pair_mismatches)
);

>>> verif/tb.sv
// Testbench for msa_column_scorer: random and directed alignments, column summaries checked
// against an in-bench prediction of the scoring. Depends on msacs_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import msacs_pkg::*;

    // One expected column summary.
    typedef struct {
        logic [SYM_W-1:0]      consensus;
        logic                  all_gap;
        logic [DIST_W-1:0]     col_dist;
        logic [PAIR_W-1:0]     col_pairs;
        logic [TOT_DIST_W-1:0] tot_dist;
        logic [TOT_PAIR_W-1:0] tot_pairs;
        logic                  shape_err;
        logic                  ovf;
        logic                  aln_end;
    } t_column_summary;

    // Predicts column summaries from accepted symbols and checks the block's summaries.
    class t_column_scoreboard;
        int unsigned     hist[DEF_ALPHABET_SIZE];
        bit              hist_valid[DEF_ALPHABET_SIZE];
        logic [7:0]      gap;
        longint unsigned seq_pos, best_cnt, col_pairs, tot_dist, tot_pairs;
        longint unsigned first_len, col_idx;
        logic [7:0]      best_sym;
        bit              shape_err, ovf_err;
        t_column_summary expected_summaries[$];
        int              mismatches;

        function new();
            gap = GAP_RESET;
            col_idx = 0; first_len = 0; tot_dist = 0; tot_pairs = 0;
            shape_err = 0; ovf_err = 0; mismatches = 0;
            open_column();
        endfunction

        function void open_column();
            foreach (hist_valid[k]) hist_valid[k] = 0;
            seq_pos = 0; best_cnt = 0; best_sym = gap; col_pairs = 0;
        endfunction

        function void set_gap(logic [7:0] g);
            gap = g;
        endfunction

        // Accepted input request: update the column and, at a column end, expect a summary.
        function void note_symbol(logic [7:0] sym, bit last_col, bit last_aln);
            longint unsigned prior, n;
            t_column_summary s;
            if (seq_pos >= DEF_MAX_SEQUENCES) begin
                ovf_err = 1;
            end else begin
                if (sym < DEF_ALPHABET_SIZE) begin
                    prior = hist_valid[sym] ? hist[sym] : 0;
                    col_pairs += seq_pos - prior;
                    hist[sym] = 32'(prior + 1);
                    hist_valid[sym] = 1;
                    if (sym != gap && (prior + 1 > best_cnt ||
                                       (prior + 1 == best_cnt && sym < best_sym))) begin
                        best_cnt = prior + 1;
                        best_sym = sym;
                    end
                end else begin
                    col_pairs += seq_pos;
                end
                seq_pos++;
            end
            if (!last_col) return;
            n = seq_pos;
            if (n < 2) shape_err = 1;
            if (col_idx == 0) first_len = n;
            else if (n != first_len) shape_err = 1;
            if (col_idx >= DEF_MAX_COLUMNS) ovf_err = 1;
            else col_idx++;
            tot_dist = tot_dist + (n - best_cnt);
            if (tot_dist > TOT_DIST_MAX) tot_dist = TOT_DIST_MAX;
            tot_pairs = tot_pairs + col_pairs;
            if (tot_pairs > TOT_PAIR_MAX) tot_pairs = TOT_PAIR_MAX;
            s.all_gap   = (best_cnt == 0);
            s.consensus = s.all_gap ? gap : best_sym;
            s.col_dist  = (n - best_cnt > DIST_FIELD_MAX) ? DIST_FIELD_MAX
                                                          : DIST_W'(n - best_cnt);
            s.col_pairs = (col_pairs > PAIR_FIELD_MAX) ? PAIR_FIELD_MAX : PAIR_W'(col_pairs);
            s.tot_dist  = TOT_DIST_W'(tot_dist);
            s.tot_pairs = TOT_PAIR_W'(tot_pairs);
            s.shape_err = shape_err;
            s.ovf       = ovf_err;
            s.aln_end   = last_aln;
            expected_summaries.push_back(s);
            open_column();
            if (last_aln) begin
                tot_dist = 0; tot_pairs = 0; shape_err = 0; ovf_err = 0;
                col_idx = 0; first_len = 0;
            end
        endfunction

        // Accepted output request: compare with the oldest expected summary.
        function void check_summary(t_column_summary got);
            t_column_summary e;
            if (expected_summaries.size() == 0) begin
                $error("unexpected column summary");
                mismatches++;
                return;
            end
            e = expected_summaries.pop_front();
            if (got.consensus !== e.consensus) begin
                $error("consensus_symbol exp %0d got %0d", e.consensus, got.consensus);
                mismatches++;
            end
            if (got.all_gap !== e.all_gap) begin
                $error("all_gap_column exp %0d got %0d", e.all_gap, got.all_gap);
                mismatches++;
            end
            if (got.col_dist !== e.col_dist) begin
                $error("column_distance exp %0d got %0d", e.col_dist, got.col_dist);
                mismatches++;
            end
            if (got.col_pairs !== e.col_pairs) begin
                $error("column_pair_mismatches exp %0d got %0d", e.col_pairs, got.col_pairs);
                mismatches++;
            end
            if (got.tot_dist !== e.tot_dist) begin
                $error("total_distance exp %0d got %0d", e.tot_dist, got.tot_dist);
                mismatches++;
            end
            if (got.tot_pairs !== e.tot_pairs) begin
                $error("total_pair_mismatches exp %0d got %0d", e.tot_pairs, got.tot_pairs);
                mismatches++;
            end
            if (got.shape_err !== e.shape_err) begin
                $error("shape_error exp %0d got %0d", e.shape_err, got.shape_err);
                mismatches++;
            end
            if (got.ovf !== e.ovf) begin
                $error("overflow exp %0d got %0d", e.ovf, got.ovf);
                mismatches++;
            end
            if (got.aln_end !== e.aln_end) begin
                $error("end_of_alignment exp %0d got %0d", e.aln_end, got.aln_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_in_valid = 0;
    logic                  o_in_stall;
    logic [SYM_W-1:0]      i_symbol = '0;
    logic                  i_last_in_column = 0;
    logic                  i_last_in_alignment = 0;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [SYM_W-1:0]      i_cfg_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 0;
    logic [SYM_W-1:0]      o_consensus_symbol;
    logic                  o_all_gap_column;
    logic [DIST_W-1:0]     o_column_distance;
    logic [PAIR_W-1:0]     o_column_pair_mismatches;
    logic [TOT_DIST_W-1:0] o_total_distance;
    logic [TOT_PAIR_W-1:0] o_total_pair_mismatches;
    logic                  o_shape_error;
    logic                  o_overflow;
    logic                  o_end_of_alignment;

    t_column_scoreboard sb = new();
    int  send_idle_pct = 35;
    int  recv_idle_pct = 45;
    int  hold_left = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  symbols_sent = 0;

    msa_column_scorer uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall: random, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Summary monitor.
    always @(posedge i_clk) begin
        t_column_summary got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.consensus = o_consensus_symbol;
            got.all_gap   = o_all_gap_column;
            got.col_dist  = o_column_distance;
            got.col_pairs = o_column_pair_mismatches;
            got.tot_dist  = o_total_distance;
            got.tot_pairs = o_total_pair_mismatches;
            got.shape_err = o_shape_error;
            got.ovf       = o_overflow;
            got.aln_end   = o_end_of_alignment;
            sb.check_summary(got);
        end
    end

    // Offer one symbol request and wait until it is taken.
    task automatic send_symbol(logic [7:0] sym, bit last_col, bit last_aln);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol <= sym;
        i_last_in_column <= last_col;
        i_last_in_alignment <= last_aln;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_symbol(sym, last_col, last_aln);
        symbols_sent++;
    endtask

    // Let every expected summary arrive, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_summaries.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_gap(logic [7:0] g);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_gap(g);
    endtask

    // Send one column given as a list of symbols.
    task automatic send_column(logic [7:0] syms[$], bit last_aln);
        foreach (syms[k]) send_symbol(syms[k], k == syms.size() - 1, last_aln);
    endtask

    // One random alignment; mostly well formed, some broken shapes and stray marks.
    task automatic send_alignment();
        int         nseq, ncols, len;
        logic [7:0] pool[4];
        logic [7:0] sym;
        nseq  = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 2);
        ncols = $urandom_range(8, 1);
        foreach (pool[k]) pool[k] = $urandom_range(255);
        for (int c = 0; c < ncols; c++) begin
            len = ($urandom_range(11) == 0) ? $urandom_range(10, 1) : nseq;
            for (int s = 0; s < len; s++) begin
                case ($urandom_range(9))
                    0:       sym = $urandom_range(255);
                    1, 2:    sym = sb.gap;
                    default: sym = pool[$urandom_range(3)];
                endcase
                send_symbol(sym, s == len - 1,
                            (s == len - 1) ? (c == ncols - 1) : ($urandom_range(7) == 0));
            end
        end
    endtask

    initial begin
        logic [7:0] col[$];
        // Hold reset at the start, then release it.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, ties, gaps, outside-alphabet symbol, stray final mark.
        col = '{8'd254, 8'd0, 8'd254, 8'd0};
        send_column(col, 0);
        col = '{8'd45, 8'd45, 8'd45, 8'd45};
        send_column(col, 0);
        send_symbol(8'd255, 0, 1);
        send_symbol(8'd7, 0, 0);
        send_symbol(8'd255, 0, 0);
        send_symbol(8'd7, 1, 0);
        col = '{8'd9, 8'd8, 8'd45};
        send_column(col, 0);
        col = '{8'd1};
        send_column(col, 1);
        // Gap register changed in the middle of a column.
        send_symbol(8'd3, 0, 0);
        send_symbol(8'd4, 0, 0);
        drain();
        write_gap(8'd3);
        send_symbol(8'd3, 0, 0);
        send_symbol(8'd4, 1, 1);
        drain();
        write_gap(8'd254);

        // Random alignments; receiver long hold-off along the way.
        while (symbols_sent < 350) begin
            if (symbols_sent > 150 && !hold_done) begin
                hold_req = 1;
                hold_done = 1;
            end
            send_alignment();
        end
        drain();
        write_gap(8'd0);
        send_idle_pct = 45;
        recv_idle_pct = 35;
        while (symbols_sent < 600) send_alignment();
        drain();
        write_gap(GAP_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (symbols_sent < 800) send_alignment();

        // Too many sequences in one column.
        for (int s = 0; s < 1030; s++) send_symbol($urandom_range(3), s == 1029, 1);
        drain();

        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
sv/msacs_pkg.sv
sv/msacs_front.sv
sv/msacs_fifo.sv
sv/msacs_back.sv
sv/msa_column_scorer.sv
sv/msacs_checker.sv
verif/tb.sv
